// ----- design/lltm_pkg.sv -----
// shared types, constants and a helper function for the coordinate text parser
// used by every other file in the design folder; depends on nothing

package lltm_pkg;

  // default count of fraction digits kept from the text
  localparam int FracDigitsDefault = 6;

  // field widths
  localparam int ChW     = 8;
  localparam int WholeW  = 10;
  localparam int FracW   = 20;
  localparam int ScaleW  = 3;
  localparam int MagW    = 30;
  localparam int DigitW  = 4;

  // whole-degree saturation point
  localparam logic [WholeW-1:0] WholeMax = 10'd1023;

  // range limits in whole degrees
  localparam logic [WholeW-1:0] LatLimit = 10'd90;
  localparam logic [WholeW-1:0] LonLimit = 10'd360;

  // scale factors in micro-degrees
  localparam logic [MagW-1:0] Micro   = 30'd1000000;
  localparam logic [MagW-1:0] LonSpan = 30'd360000000;

  // character codes
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChDot   = 8'h2E;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChUpN   = 8'h4E;
  localparam logic [ChW-1:0] ChLowN  = 8'h6E;
  localparam logic [ChW-1:0] ChUpS   = 8'h53;
  localparam logic [ChW-1:0] ChLowS  = 8'h73;
  localparam logic [ChW-1:0] ChUpE   = 8'h45;
  localparam logic [ChW-1:0] ChLowE  = 8'h65;
  localparam logic [ChW-1:0] ChUpW   = 8'h57;
  localparam logic [ChW-1:0] ChLowW  = 8'h77;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_t;

  // completed term handed from the character scanner to the result stage
  typedef struct packed {
    logic              lon;
    logic              negative;
    logic              bad_character;
    logic [WholeW-1:0] whole_degrees;
    logic [FracW-1:0]  frac_six;
    logic [ScaleW-1:0] six_digits;
    logic              frac_nonzero;
  } term_t;

  // multiplier that brings a fraction of the given digit count to six digits
  function automatic logic [FracW-1:0] frac_scale(input logic [ScaleW-1:0] kept);
    logic [FracW-1:0] f;
    case (kept)
      3'd0:    f = 20'd1000000;
      3'd1:    f = 20'd100000;
      3'd2:    f = 20'd10000;
      3'd3:    f = 20'd1000;
      3'd4:    f = 20'd100;
      3'd5:    f = 20'd10;
      default: f = 20'd1;
    endcase
    return f;
  endfunction

endpackage

// ----- design/lltm_char_if.sv -----
// character request channel: one text character with its mode and end mark
// depends on lltm_pkg for field widths

interface lltm_char_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [lltm_pkg::ChW-1:0]  ch;
  logic                      last;

  modport source (output valid, output func, output ch, output last, input ready);
  modport sink   (input valid, input func, input ch, input last, output ready);
endinterface

// ----- design/lltm_result_if.sv -----
// result request channel: one coordinate in micro-degrees with its status
// depends on lltm_pkg for widths and the status type

interface lltm_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [lltm_pkg::MagW-1:0] micro_degrees;
  lltm_pkg::status_t                status;

  modport source (output valid, output micro_degrees, output status, input ready);
  modport sink   (input valid, input micro_degrees, input status, output ready);
endinterface

// ----- design/lltm_scan.sv -----
// per-character scanner: keeps sign, dot state and decimal digits of one term
// depends on lltm_pkg; presents the finished term for the character marked last

module lltm_scan #(
  parameter int FRAC_DIGITS = lltm_pkg::FracDigitsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic                     func,
  input  logic [lltm_pkg::ChW-1:0] ch,
  input  logic                     last,
  output lltm_pkg::term_t          term
);

  localparam int CntW    = $clog2(FRAC_DIGITS + 1);
  localparam int SixKeep = (FRAC_DIGITS < 6) ? FRAC_DIGITS : 6;
  localparam int WholeW  = lltm_pkg::WholeW;
  localparam int FracW   = lltm_pkg::FracW;
  localparam int ScaleW  = lltm_pkg::ScaleW;
  localparam int DigitW  = lltm_pkg::DigitW;
  localparam int ProdW   = WholeW + DigitW;
  localparam logic [CntW-1:0] CntMax = CntW'(FRAC_DIGITS);
  localparam logic [CntW-1:0] SixMax = CntW'(SixKeep);

  logic              negative, negative_next;
  logic              dot_seen, dot_seen_next;
  logic              number_ended, number_ended_next;
  logic [WholeW-1:0] whole_degrees, whole_degrees_next;
  logic [FracW-1:0]  frac_six, frac_six_next;
  logic [CntW-1:0]   fraction_digits, fraction_digits_next;
  logic              frac_nonzero, frac_nonzero_next;
  logic              bad_character, bad_character_next;

  logic              is_digit;
  logic [DigitW-1:0] digit;
  logic [ProdW-1:0]  whole_prod;
  logic [CntW-1:0]   six_cnt;

  assign is_digit   = (ch >= lltm_pkg::ChZero) && (ch <= lltm_pkg::ChNine);
  assign digit      = ch[DigitW-1:0];
  assign whole_prod = ProdW'(whole_degrees) * ProdW'(10) + ProdW'(digit);

  // character classification and digit accumulation
  always_comb begin
    negative_next        = negative;
    dot_seen_next        = dot_seen;
    number_ended_next    = number_ended;
    whole_degrees_next   = whole_degrees;
    frac_six_next        = frac_six;
    fraction_digits_next = fraction_digits;
    frac_nonzero_next    = frac_nonzero;
    bad_character_next   = bad_character;
    if (ch == lltm_pkg::ChMinus) begin
      negative_next = 1'b1;
    end else if (is_digit) begin
      if (!number_ended) begin
        if (!dot_seen) begin
          whole_degrees_next = (whole_prod > ProdW'(lltm_pkg::WholeMax)) ?
                               lltm_pkg::WholeMax : whole_prod[WholeW-1:0];
        end else if (fraction_digits < CntMax) begin
          fraction_digits_next = fraction_digits + CntW'(1);
          frac_nonzero_next    = frac_nonzero | (digit != '0);
          if (fraction_digits < SixMax) begin
            frac_six_next = frac_six * FracW'(10) + FracW'(digit);
          end
        end
      end
    end else if (ch == lltm_pkg::ChDot) begin
      if (dot_seen) begin
        number_ended_next = 1'b1;
      end else begin
        dot_seen_next = 1'b1;
      end
    end else if (!func && (ch == lltm_pkg::ChUpN || ch == lltm_pkg::ChLowN)) begin
      negative_next = 1'b0;
    end else if (!func && (ch == lltm_pkg::ChUpS || ch == lltm_pkg::ChLowS)) begin
      negative_next = 1'b1;
    end else if (func && (ch == lltm_pkg::ChUpE || ch == lltm_pkg::ChLowE)) begin
      negative_next = 1'b0;
    end else if (func && (ch == lltm_pkg::ChUpW || ch == lltm_pkg::ChLowW)) begin
      negative_next = 1'b1;
    end else begin
      bad_character_next = 1'b1;
    end
  end

  // finished term as it stands after this character
  assign six_cnt = (fraction_digits_next > SixMax) ? SixMax : fraction_digits_next;

  always_comb begin
    term.lon           = func;
    term.negative      = negative_next;
    term.bad_character = bad_character_next;
    term.whole_degrees = whole_degrees_next;
    term.frac_six      = frac_six_next;
    term.six_digits    = ScaleW'(six_cnt);
    term.frac_nonzero  = frac_nonzero_next;
  end

  // term state, cleared on reset and after the last character
  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      negative        <= 1'b0;
      dot_seen        <= 1'b0;
      number_ended    <= 1'b0;
      whole_degrees   <= '0;
      frac_six        <= '0;
      fraction_digits <= '0;
      frac_nonzero    <= 1'b0;
      bad_character   <= 1'b0;
    end else if (take) begin
      negative        <= negative_next;
      dot_seen        <= dot_seen_next;
      number_ended    <= number_ended_next;
      whole_degrees   <= whole_degrees_next;
      frac_six        <= frac_six_next;
      fraction_digits <= fraction_digits_next;
      frac_nonzero    <= frac_nonzero_next;
      bad_character   <= bad_character_next;
    end
  end

endmodule

// ----- design/lltm_scale.sv -----
// result logic: range check, fixed-point scaling and sign rule of one term
// depends on lltm_pkg for the term structure, constants and status codes

module lltm_scale (
  input  lltm_pkg::term_t                  term,
  output logic signed [lltm_pkg::MagW-1:0] micro_degrees,
  output lltm_pkg::status_t                status
);

  localparam int MagW  = lltm_pkg::MagW;
  localparam int FracW = lltm_pkg::FracW;

  logic [lltm_pkg::WholeW-1:0] limit;
  logic [MagW-1:0]             whole_mag;
  logic [FracW-1:0]            frac6;
  logic [MagW-1:0]             mag;
  logic [MagW-1:0]             value;

  // magnitude in micro-degrees
  assign limit     = term.lon ? lltm_pkg::LonLimit : lltm_pkg::LatLimit;
  assign whole_mag = MagW'(term.whole_degrees) * lltm_pkg::Micro;
  assign frac6     = term.frac_six * lltm_pkg::frac_scale(term.six_digits);
  assign mag       = whole_mag + MagW'(frac6);

  // status priority and sign rule
  always_comb begin
    value = '0;
    if (term.bad_character) begin
      status = lltm_pkg::STATUS_BAD_CHAR;
    end else if ((term.whole_degrees > limit) ||
                 ((term.whole_degrees == limit) && term.frac_nonzero)) begin
      status = lltm_pkg::STATUS_RANGE;
    end else begin
      status = lltm_pkg::STATUS_OK;
      if (term.lon) begin
        value = term.negative ? (lltm_pkg::LonSpan - mag) : mag;
      end else begin
        value = term.negative ? (MagW'(0) - mag) : mag;
      end
    end
  end

  assign micro_degrees = $signed(value);

endmodule

// ----- design/lat_lon_text_to_microdegrees_core.sv -----
// Coordinate text parser: turns one latitude or longitude term, sent one
// ASCII character per request on the text channel, into a signed count of
// micro-degrees on the coord channel.
//
// Each text request carries func (0 latitude, 1 longitude), ch and last.
// Digits, one dot and further fraction digits build the number; '-', N/S
// or E/W set the sign and the last such character wins; a second dot ends
// the number. The request with last set yields exactly one coord request:
// latitude signed within 90 degrees, longitude 0..360 with west taken as
// 360 minus the value, or 0 with status 1 (bad character) or 2 (range).
//
// Throughput is one character per cycle while the term register is free or
// can move on. After its last character is accepted, a coord request
// passes two registers: one for the finished term, one for the scaled
// result. The scanner multiplies its sums by ten; the result stage scales
// by one million and a power of ten. When coord is stalled, the term
// register holds one more finished term and text keeps taking characters
// until it is full. Reset clears the term in progress and both valid flags.
// depends on lltm_pkg, lltm_char_if, lltm_result_if, lltm_scan, lltm_scale

module lat_lon_text_to_microdegrees_core #(
  parameter int FRAC_DIGITS = lltm_pkg::FracDigitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  lltm_char_if.sink            text,
  lltm_result_if.source        coord
);

  lltm_pkg::term_t                  term_next;
  lltm_pkg::term_t                  term;
  logic                             term_valid;
  logic signed [lltm_pkg::MagW-1:0] result_value;
  lltm_pkg::status_t                result_status;
  logic signed [lltm_pkg::MagW-1:0] micro_degrees;
  lltm_pkg::status_t                status;
  logic                             coord_valid;
  logic                             out_free;
  logic                             term_move;
  logic                             take;

  // handshake control
  assign out_free   = !coord_valid || coord.ready;
  assign term_move  = term_valid && out_free;
  assign text.ready = !term_valid || out_free;
  assign take       = text.valid && text.ready;

  // per-character scanner
  lltm_scan #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .func (text.func),
    .ch   (text.ch),
    .last (text.last),
    .term (term_next)
  );

  // finished term register
  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else if (take && text.last) begin
      term_valid <= 1'b1;
    end else if (term_move) begin
      term_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && text.last) begin
      term <= term_next;
    end
  end

  // scaling and range check
  lltm_scale u_scale (
    .term          (term),
    .micro_degrees (result_value),
    .status        (result_status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      coord_valid <= 1'b0;
    end else if (term_move) begin
      coord_valid <= 1'b1;
    end else if (coord.ready) begin
      coord_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term_move) begin
      micro_degrees <= result_value;
      status        <= result_status;
    end
  end

  assign coord.valid         = coord_valid;
  assign coord.micro_degrees = micro_degrees;
  assign coord.status        = status;

endmodule

// ----- tb/tb_top.sv -----
// testbench for lat_lon_text_to_microdegrees_core: streams coordinate terms one
// character per request and checks each coord request against a term predictor
// depends on lltm_pkg, lltm_char_if, lltm_result_if and the core itself

module tb_top;
  import lltm_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int CharTarget  = 1500;
  localparam int DrainCycles = 10;
  localparam int KeptDigits  = FracDigitsDefault;

  // term predictor and queue of expected coordinates
  class coord_scoreboard;
    typedef struct {
      logic [MagW-1:0] micro_degrees;
      status_t         status;
    } coord_t;

    coord_t             expected_q[$];
    int unsigned        errors;
    int unsigned        coords_seen;
    bit                 negative;
    bit                 dot_seen;
    bit                 number_ended;
    bit                 bad_character;
    bit [WholeW-1:0]    whole_degrees;
    bit [FracW-1:0]     fraction_value;
    bit [ScaleW-1:0]    fraction_digits;

    function new();
      errors      = 0;
      coords_seen = 0;
      clear_term();
    endfunction

    function void clear_term();
      negative        = 1'b0;
      dot_seen        = 1'b0;
      number_ended    = 1'b0;
      bad_character   = 1'b0;
      whole_degrees   = '0;
      fraction_value  = '0;
      fraction_digits = '0;
    endfunction

    // fold one accepted character into the term, predict a coord on the last one
    function void note_char(bit lon, bit [ChW-1:0] c, bit last);
      int unsigned acc;
      int unsigned limit;
      int unsigned scale;
      int unsigned mag;
      int unsigned value;
      coord_t      want;
      if (c == ChMinus) begin
        negative = 1'b1;
      end else if (c >= ChZero && c <= ChNine) begin
        if (!number_ended) begin
          if (!dot_seen) begin
            acc = 32'(whole_degrees) * 10 + 32'(c - ChZero);
            whole_degrees = (acc > 32'(WholeMax)) ? WholeMax : acc[WholeW-1:0];
          end else if (fraction_digits < KeptDigits) begin
            fraction_value  = FracW'(32'(fraction_value) * 10 + 32'(c - ChZero));
            fraction_digits = ScaleW'(32'(fraction_digits) + 1);
          end
        end
      end else if (c == ChDot) begin
        if (dot_seen) number_ended = 1'b1;
        else dot_seen = 1'b1;
      end else if (!lon && (c == ChUpN || c == ChLowN)) begin
        negative = 1'b0;
      end else if (!lon && (c == ChUpS || c == ChLowS)) begin
        negative = 1'b1;
      end else if (lon && (c == ChUpE || c == ChLowE)) begin
        negative = 1'b0;
      end else if (lon && (c == ChUpW || c == ChLowW)) begin
        negative = 1'b1;
      end else begin
        bad_character = 1'b1;
      end
      if (!last) return;

      // finished term: error codes first, then the signed or wrapped value
      limit = lon ? 32'(LonLimit) : 32'(LatLimit);
      value = 0;
      if (bad_character) begin
        want.status = STATUS_BAD_CHAR;
      end else if (32'(whole_degrees) > limit ||
                   (32'(whole_degrees) == limit && fraction_value != 0)) begin
        want.status = STATUS_RANGE;
      end else begin
        want.status = STATUS_OK;
        scale = 1;
        repeat (6 - fraction_digits) scale = scale * 10;
        mag = 32'(whole_degrees) * 32'(Micro) + 32'(fraction_value) * scale;
        if (lon) value = negative ? (32'(LonSpan) - mag) : mag;
        else value = negative ? (0 - mag) : mag;
      end
      want.micro_degrees = value[MagW-1:0];
      expected_q.push_back(want);
      clear_term();
    endfunction

    task report(string msg);
      $display("mismatch at coord %0d: %s", coords_seen, msg);
      errors++;
    endtask

    // compare one accepted coord with the oldest expectation
    task check_coord(logic [MagW-1:0] md, status_t st);
      coord_t want;
      coords_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected coord %0d status %0d", $signed(md), st));
        return;
      end
      want = expected_q.pop_front();
      if (md !== want.micro_degrees)
        report($sformatf("micro_degrees %0d, want %0d", $signed(md),
                         $signed(want.micro_degrees)));
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  lltm_char_if   text_if ();
  lltm_result_if coord_if ();

  lat_lon_text_to_microdegrees_core u_top (
    .clk   (clk),
    .rst   (rst),
    .text  (text_if),
    .coord (coord_if)
  );

  coord_scoreboard sb;
  bit [ChW-1:0]    term_ch[$];
  bit              term_fn[$];
  int              burst_left;
  int              chars_sent;
  int unsigned     cycle_count = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // coord monitor
  always @(posedge clk) begin
    if (!rst && coord_if.valid && coord_if.ready)
      sb.check_coord(coord_if.micro_degrees, coord_if.status);
  end

  // coord receiver: stall pattern switches at random between four modes
  initial begin
    int mode;
    int mode_left;
    int tick;
    coord_if.ready = 1'b0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        0: coord_if.ready = 1'b1;
        1: coord_if.ready = 1'($urandom_range(0, 1));
        2: coord_if.ready = ($urandom_range(0, 7) == 0);
        default: coord_if.ready = ((tick % 5) < 2);
      endcase
    end
  end

  task automatic push_char(bit fn, bit [ChW-1:0] c);
    term_ch.push_back(c);
    term_fn.push_back(fn);
  endtask

  task automatic add_text(bit fn, string s);
    for (int i = 0; i < s.len(); i++) push_char(fn, s[i]);
  endtask

  function automatic bit [ChW-1:0] sign_letter(bit fn);
    bit [ChW-1:0] c;
    case ($urandom_range(0, 3))
      0: c = fn ? ChUpE : ChUpN;
      1: c = fn ? ChLowE : ChLowN;
      2: c = fn ? ChUpW : ChUpS;
      default: c = fn ? ChLowW : ChLowS;
    endcase
    return c;
  endfunction

  // send the queued term in bursts with random idle gaps
  task automatic send_term();
    for (int i = 0; i < term_ch.size(); i++) begin
      if (burst_left == 0) begin
        text_if.valid = 1'b0;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2))
          @(negedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 20);
      end
      text_if.valid = 1'b1;
      text_if.func  = term_fn[i];
      text_if.ch    = term_ch[i];
      text_if.last  = (i == term_ch.size() - 1);
      @(posedge clk);
      while (!text_if.ready) @(posedge clk);
      sb.note_char(term_fn[i], term_ch[i], i == term_ch.size() - 1);
      chars_sent++;
      burst_left--;
      @(negedge clk);
    end
    term_ch.delete();
    term_fn.delete();
  endtask

  // mostly well-formed terms with random content, some noise and mixed modes
  task automatic build_random_term();
    bit    fn;
    int    kind;
    int    limit;
    int    w;
    int    n;
    string s;
    fn = 1'($urandom_range(0, 1));
    limit = fn ? 360 : 90;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 1)) push_char(fn, ChW'($urandom_range(0, 255)));
        else push_char(1'($urandom_range(0, 1)), sign_letter(1'($urandom_range(0, 1))));
      end
    end else begin
      if ($urandom_range(0, 3) == 0) push_char(fn, ChMinus);
      if ($urandom_range(0, 9) == 0) push_char(fn, sign_letter(fn));
      repeat ($urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0) push_char(fn, ChZero);
      // whole part near the limit, anywhere, past saturation, or absent
      w = -1;
      case ($urandom_range(0, 5))
        0: w = limit;
        1: w = limit - 1;
        2: w = $urandom_range(0, limit);
        3: w = $urandom_range(0, 1200);
        4: w = -1;
        default: w = $urandom_range(0, 9);
      endcase
      if (w >= 0) begin
        s = $sformatf("%0d", w);
        add_text(fn, s);
      end
      // fraction, sometimes past the kept digits, sometimes cut by a second dot
      if ($urandom_range(0, 3) != 0) begin
        push_char(fn, ChDot);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) repeat (n) push_char(fn, ChZero);
        else repeat (n) push_char(fn, ChW'(ChZero + $urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0) begin
          push_char(fn, ChDot);
          repeat ($urandom_range(0, 3)) push_char(fn, ChW'(ChZero + $urandom_range(0, 9)));
          if ($urandom_range(0, 1)) push_char(fn, ChDot);
        end
      end
      if ($urandom_range(0, 1)) push_char(fn, sign_letter(fn));
      if (kind == 1) push_char(fn, ChW'($urandom_range(0, 255)));
      if (term_ch.size() == 0) push_char(fn, ChW'(ChZero + $urandom_range(0, 9)));
      if (kind == 2) begin
        foreach (term_fn[i]) term_fn[i] = 1'($urandom_range(0, 1));
      end
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    rst = 1'b1;
    text_if.valid = 1'b0;
    text_if.func  = 1'b0;
    text_if.ch    = '0;
    text_if.last  = 1'b0;
    burst_left = 0;
    chars_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // southern limit
    add_text(1'b0, "90S");
    send_term();
    // latitude just over the limit
    add_text(1'b0, "90.1");
    send_term();
    // western zero longitude
    add_text(1'b1, "w");
    send_term();
    // empty number
    add_text(1'b0, ".");
    send_term();
    // second dot ends the number
    add_text(1'b1, "1.2.3e");
    send_term();
    // negative zero latitude
    add_text(1'b0, "-");
    send_term();
    // invalid characters at both ends of the byte range
    push_char(1'b0, 8'h00);
    push_char(1'b0, 8'hFF);
    send_term();
    // whole-degree saturation
    add_text(1'b0, "9999");
    send_term();
    // longitude letter given in latitude mode
    add_text(1'b0, "E");
    send_term();

    while (chars_sent < CharTarget) begin
      build_random_term();
      send_term();
    end
    text_if.valid = 1'b0;
    text_if.last  = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lltm_pkg.sv
design/lltm_char_if.sv
design/lltm_result_if.sv
design/lltm_scan.sv
design/lltm_scale.sv
design/lat_lon_text_to_microdegrees_core.sv
tb/tb_top.sv
